@@ src/tcce_pkg.sv @@
package tcce_pkg;

	localparam int ROW_COUNT  = 25;
	localparam int COL_COUNT  = 80;
	localparam int CELL_TOTAL = ROW_COUNT * COL_COUNT;
	localparam int ADDR_W     = $clog2(CELL_TOTAL);

	localparam int FUNC_W = 3;
	localparam int CHAR_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;

	localparam logic [FUNC_W-1:0] FUNC_PRINT  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_MOVE   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] BLANK_RESET  = 8'h0F;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COL_COUNT - 1);

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CHAR_W-1:0] char_code;
		logic [CHAR_W-1:0] color;
		logic [ROW_W-1:0]  target_row;
		logic [COL_W-1:0]  target_col;
	} cmd_word_t;

	typedef struct packed {
		logic [ROW_W-1:0]  cursor_row_out;
		logic [COL_W-1:0]  cursor_col_out;
		logic [POS_W-1:0]  cursor_position;
		logic [CELL_W-1:0] cell_value;
		logic              scrolled;
		logic              ignored;
	} rsp_word_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic sweep_clr;
		logic sweep_inc;
		logic init_wr;
		logic clear_wr;
		logic copy_rd;
		logic copy_wr;
		logic blank_wr;
		logic cap_cell;
		logic load_out;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic need_scroll;
		logic need_clear;
		logic need_read;
		logic cnt_zero;
		logic cnt_copy_end;
		logic cnt_end;
	} sts_t;

endpackage

@@ src/tcce_ram.sv @@
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/tcce_ctrl.sv @@
module tcce_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  tcce_pkg::sts_t sts,
	output tcce_pkg::ctl_t ctl
);
	import tcce_pkg::*;

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECODE = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_SCROLL = 3'd4;
	localparam logic [2:0] S_BLANK  = 3'd5;
	localparam logic [2:0] S_CLEAR  = 3'd6;
	localparam logic [2:0] S_FINISH = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				ctl.init_wr = 1'b1;
				if (sts.cnt_end) begin
					state_d = S_IDLE;
				end else begin
					ctl.sweep_inc = 1'b1;
				end
			end
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				ctl.exec      = 1'b1;
				ctl.sweep_clr = 1'b1;
				if (sts.need_scroll) begin
					state_d = S_SCROLL;
				end else if (sts.need_clear) begin
					state_d = S_CLEAR;
				end else if (sts.need_read) begin
					state_d = S_READ;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_READ: begin
				ctl.cap_cell = 1'b1;
				state_d      = S_FINISH;
			end
			S_SCROLL: begin
				// read one row ahead, write back what the last cycle read
				ctl.copy_rd = !sts.cnt_copy_end;
				ctl.copy_wr = !sts.cnt_zero;
				if (sts.cnt_copy_end) begin
					state_d = S_BLANK;
				end else begin
					ctl.sweep_inc = 1'b1;
				end
			end
			S_BLANK: begin
				ctl.blank_wr = 1'b1;
				if (sts.cnt_end) begin
					state_d = S_FINISH;
				end else begin
					ctl.sweep_inc = 1'b1;
				end
			end
			S_CLEAR: begin
				ctl.clear_wr = 1'b1;
				if (sts.cnt_end) begin
					state_d = S_FINISH;
				end else begin
					ctl.sweep_inc = 1'b1;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/tcce_dp.sv @@
module tcce_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcce_pkg::cmd_word_t  cmd_word,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	input  tcce_pkg::ctl_t       ctl,
	output tcce_pkg::sts_t       sts,
	output tcce_pkg::rsp_word_t  rsp_word
);
	import tcce_pkg::*;

	cmd_word_t          cmd_q;
	rsp_word_t          rsp_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [CHAR_W-1:0]  blank_color_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic [CELL_W-1:0]  cell_q;
	logic               scrolled_q;
	logic               ignored_q;

	logic [ADDR_W-1:0]  cur_addr;
	logic [ADDR_W-1:0]  tgt_addr;
	logic [CELL_W-1:0]  blank_cell;
	logic               is_print;
	logic               is_nl;
	logic               is_cr;
	logic               print_wr;
	logic               nl_step;
	logic               col_wrap;
	logic               row_last;
	logic               at_origin;
	logic               tgt_ok;
	logic               ignore;

	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [CELL_W-1:0]  wr_data;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [CELL_W-1:0]  rd_data;

	assign cur_addr   = ADDR_W'(row_q) * ADDR_W'(COL_COUNT) + ADDR_W'(col_q);
	assign tgt_addr   = ADDR_W'(cmd_q.target_row) * ADDR_W'(COL_COUNT)
		+ ADDR_W'(cmd_q.target_col);
	assign blank_cell = {blank_color_q, CHAR_SPACE};

	assign is_print  = (cmd_q.func == FUNC_PRINT);
	assign is_nl     = (cmd_q.char_code == CHAR_NEWLINE);
	assign is_cr     = (cmd_q.char_code == CHAR_RETURN);
	assign print_wr  = is_print && !is_nl && !is_cr;
	assign col_wrap  = (int'(col_q) + 1 >= COL_COUNT);
	assign row_last  = (int'(row_q) + 1 >= ROW_COUNT);
	assign nl_step   = is_print && (is_nl || (print_wr && col_wrap));
	assign at_origin = (row_q == '0) && (col_q == '0);
	assign tgt_ok    = (int'(cmd_q.target_row) < ROW_COUNT)
		&& (int'(cmd_q.target_col) < COL_COUNT);

	always_comb begin
		case (cmd_q.func)
			FUNC_PRINT:  ignore = is_cr;
			FUNC_DELETE: ignore = at_origin;
			FUNC_MOVE:   ignore = !tgt_ok;
			FUNC_CLEAR:  ignore = 1'b0;
			FUNC_READ:   ignore = !tgt_ok;
			default:     ignore = 1'b1;
		endcase
	end

	assign sts.need_scroll  = nl_step && row_last;
	assign sts.need_clear   = (cmd_q.func == FUNC_CLEAR);
	assign sts.need_read    = (cmd_q.func == FUNC_READ) && tgt_ok;
	assign sts.cnt_zero     = (cnt_q == '0);
	assign sts.cnt_copy_end = (cnt_q == ADDR_W'(CELL_TOTAL - COL_COUNT));
	assign sts.cnt_end      = (cnt_q == ADDR_W'(CELL_TOTAL - 1));

	// store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q;
		wr_data = blank_cell;
		if (ctl.exec && print_wr) begin
			wr_en   = 1'b1;
			wr_addr = cur_addr;
			wr_data = {cmd_q.color, cmd_q.char_code};
		end
		if (ctl.exec && (cmd_q.func == FUNC_DELETE) && !at_origin) begin
			// the cell before the cursor, row starts included
			wr_en   = 1'b1;
			wr_addr = cur_addr - ADDR_W'(1);
		end
		if (ctl.init_wr) begin
			wr_en   = 1'b1;
			wr_data = {BLANK_RESET, CHAR_SPACE};
		end
		if (ctl.clear_wr || ctl.blank_wr) begin
			wr_en = 1'b1;
		end
		if (ctl.copy_wr) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q - ADDR_W'(1);
			wr_data = rd_data;
		end
	end

	assign rd_en   = ctl.copy_rd || (ctl.exec && sts.need_read);
	assign rd_addr = ctl.copy_rd ? (cnt_q + ADDR_W'(COL_COUNT)) : tgt_addr;

	tcce_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_TOTAL)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q         <= '0;
			col_q         <= '0;
			cnt_q         <= '0;
			blank_color_q <= BLANK_RESET;
		end else begin
			if (cfg_we) begin
				blank_color_q <= cfg_wdata;
			end
			if (ctl.sweep_clr) begin
				cnt_q <= '0;
			end else if (ctl.sweep_inc) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			if (ctl.exec) begin
				case (cmd_q.func)
					FUNC_PRINT: begin
						if (nl_step) begin
							col_q <= '0;
							row_q <= row_last ? ROW_LAST : row_q + ROW_W'(1);
						end else if (print_wr) begin
							col_q <= col_q + COL_W'(1);
						end
					end
					FUNC_DELETE: begin
						if (col_q != '0) begin
							col_q <= col_q - COL_W'(1);
						end else if (row_q != '0) begin
							row_q <= row_q - ROW_W'(1);
							col_q <= COL_LAST;
						end
					end
					FUNC_MOVE: begin
						if (tgt_ok) begin
							row_q <= cmd_q.target_row;
							col_q <= cmd_q.target_col;
						end
					end
					FUNC_CLEAR: begin
						row_q <= '0;
						col_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= cmd_word;
		end
		if (ctl.exec) begin
			cell_q     <= '0;
			scrolled_q <= sts.need_scroll;
			ignored_q  <= ignore;
		end else if (ctl.cap_cell) begin
			cell_q <= rd_data;
		end
		if (ctl.load_out) begin
			rsp_q.cursor_row_out  <= row_q;
			rsp_q.cursor_col_out  <= col_q;
			rsp_q.cursor_position <= POS_W'(cur_addr);
			rsp_q.cell_value      <= cell_q;
			rsp_q.scrolled        <= scrolled_q;
			rsp_q.ignored         <= ignored_q;
		end
	end

	assign rsp_word = rsp_q;

endmodule

@@ src/text_console_cursor_engine_unit.sv @@
// Print, delete, move and ignored commands go from accept through DECODE to FINISH;
// read adds a READ state, a print that scrolls sweeps the store in SCROLL and BLANK,
// and clear sweeps it in CLEAR. The single write port of the screen store sets the
// sweep lengths. A command word is taken only in IDLE, so one runs at a time; a result
// may wait on rsp_stall while the next command is taken. After arst_n the store is
// blanked with cmd_stall high; cursor resets to 0, blank 0x0F.
module text_console_cursor_engine_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  tcce_pkg::cmd_word_t  cmd_word,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output tcce_pkg::rsp_word_t  rsp_word,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata
);
	import tcce_pkg::*;

	ctl_t ctl;
	sts_t sts;

	tcce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	tcce_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_word  (cmd_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_word  (rsp_word)
	);

endmodule

@@ src/tcce_chk.sv @@
module tcce_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_stall,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input tcce_pkg::rsp_word_t  rsp_word
);
	import tcce_pkg::*;

	// one command word in flight: input stalls right after an accept
	a_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command word taken while another is in flight");

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("result word changed while stalled");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp_word.cursor_row_out) < ROW_COUNT)
			&& (int'(rsp_word.cursor_col_out) < COL_COUNT))
		else $error("cursor outside the screen");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_word.cursor_position == POS_W'(
			int'(rsp_word.cursor_row_out) * COL_COUNT + int'(rsp_word.cursor_col_out)))
		else $error("cursor position does not match row and column");

	// a scroll always moves the cursor to column 0 of the last row
	a_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.scrolled |-> !rsp_word.ignored
			&& (rsp_word.cursor_col_out == '0) && (rsp_word.cursor_row_out == ROW_LAST))
		else $error("scroll result inconsistent");

endmodule

bind text_console_cursor_engine_unit tcce_chk u_chk (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import tcce_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int TAIL_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int FUNC_TOP    = (1 << FUNC_W) - 1;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	cmd_word_t  cmd_word;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_word_t  rsp_word;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	text_console_cursor_engine_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// console model state
	logic [CELL_W-1:0] screen [0:CELL_TOTAL-1];
	int unsigned       cur_row;
	int unsigned       cur_col;
	logic [7:0]        blank_color;

	rsp_word_t pending_rsps[$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        hold_left = 0;
	int        send_idle_pct = 0;
	int        rsp_idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall plus a counted hold-off stretch
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rsp_idle_pct);
	end

	function automatic logic [CELL_W-1:0] blank_cell();
		return {blank_color, CHAR_SPACE};
	endfunction

	function automatic void blank_screen();
		for (int i = 0; i < CELL_TOTAL; i++)
			screen[i] = blank_cell();
	endfunction

	// cursor to start of next row; scrolls at the bottom
	function automatic bit next_row();
		cur_col = 0;
		if (cur_row + 1 >= ROW_COUNT) begin
			for (int i = 0; i + COL_COUNT < CELL_TOTAL; i++)
				screen[i] = screen[i + COL_COUNT];
			for (int i = CELL_TOTAL - COL_COUNT; i < CELL_TOTAL; i++)
				screen[i] = blank_cell();
			cur_row = ROW_COUNT - 1;
			return 1'b1;
		end
		cur_row++;
		return 1'b0;
	endfunction

	function automatic rsp_word_t console_step(input cmd_word_t c);
		rsp_word_t   r;
		int unsigned trow;
		int unsigned tcol;
		bit          in_range;
		r = '0;
		trow = c.target_row;
		tcol = c.target_col;
		in_range = (trow < ROW_COUNT) && (tcol < COL_COUNT);
		case (c.func)
			FUNC_PRINT: begin
				if (c.char_code == CHAR_NEWLINE) begin
					r.scrolled = next_row();
				end else if (c.char_code == CHAR_RETURN) begin
					r.ignored = 1'b1;
				end else begin
					screen[cur_row * COL_COUNT + cur_col] = {c.color, c.char_code};
					cur_col++;
					if (cur_col >= COL_COUNT)
						r.scrolled = next_row();
				end
			end
			FUNC_DELETE: begin
				if (cur_col > 0 || cur_row > 0) begin
					if (cur_col > 0) begin
						cur_col--;
					end else begin
						cur_row--;
						cur_col = COL_COUNT - 1;
					end
					screen[cur_row * COL_COUNT + cur_col] = blank_cell();
				end else begin
					r.ignored = 1'b1;
				end
			end
			FUNC_MOVE: begin
				if (in_range) begin
					cur_row = trow;
					cur_col = tcol;
				end else begin
					r.ignored = 1'b1;
				end
			end
			FUNC_CLEAR: begin
				blank_screen();
				cur_row = 0;
				cur_col = 0;
			end
			FUNC_READ: begin
				if (in_range)
					r.cell_value = screen[trow * COL_COUNT + tcol];
				else
					r.ignored = 1'b1;
			end
			default: begin
				r.ignored = 1'b1;
			end
		endcase
		r.cursor_row_out  = ROW_W'(cur_row);
		r.cursor_col_out  = COL_W'(cur_col);
		r.cursor_position = POS_W'(cur_row * COL_COUNT + cur_col);
		return r;
	endfunction

	function automatic cmd_word_t make_cmd(input logic [FUNC_W-1:0] f,
			input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] col_attr,
			input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
		cmd_word_t c;
		c.func       = f;
		c.char_code  = ch;
		c.color      = col_attr;
		c.target_row = row;
		c.target_col = col;
		return c;
	endfunction

	// mostly text with cursor moves, some reads, deletes, clears and junk
	function automatic cmd_word_t random_cmd();
		cmd_word_t   c;
		int unsigned pick;
		c = make_cmd(FUNC_PRINT, CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)),
			ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
		pick = $urandom_range(99);
		if (pick < 58) begin
			if (pick < 3)
				c.char_code = CHAR_NEWLINE;
			else if (pick < 5)
				c.char_code = CHAR_RETURN;
		end else if (pick < 72) begin
			c.func = FUNC_DELETE;
		end else if (pick < 84 || (pick >= 86 && pick < 97)) begin
			c.func = (pick < 84) ? FUNC_MOVE : FUNC_READ;
			if ($urandom_range(6) != 0) begin
				c.target_row = ROW_W'($urandom_range(ROW_COUNT - 1));
				c.target_col = COL_W'($urandom_range(COL_COUNT - 1));
				// bias moves toward the bottom row so printing scrolls
				if (c.func == FUNC_MOVE && $urandom_range(3) == 0)
					c.target_row = ROW_LAST;
			end
		end else if (pick < 86) begin
			c.func = FUNC_CLEAR;
		end else begin
			c.func = FUNC_W'($urandom_range(FUNC_TOP, FUNC_READ + 1));
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_word_t c);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= c;
		@(posedge clk);
		while (cmd_stall !== 1'b0)
			@(posedge clk);
		pending_rsps.push_back(console_step(c));
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_blank(input logic [7:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		blank_color = value;
	endtask

	always @(posedge clk) begin : check_rsp
		rsp_word_t want;
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: row=%0d col=%0d cell=%h",
						rsp_word.cursor_row_out, rsp_word.cursor_col_out,
						rsp_word.cell_value);
			end else begin
				want = pending_rsps.pop_front();
				if (rsp_word.cursor_row_out !== want.cursor_row_out ||
						rsp_word.cursor_col_out !== want.cursor_col_out ||
						rsp_word.cursor_position !== want.cursor_position ||
						rsp_word.cell_value !== want.cell_value ||
						rsp_word.scrolled !== want.scrolled ||
						rsp_word.ignored !== want.ignored) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: expected row=%0d col=%0d pos=%0d cell=%h ",
							"scr=%b ign=%b, got row=%0d col=%0d pos=%0d cell=%h scr=%b ign=%b"},
							want.cursor_row_out, want.cursor_col_out,
							want.cursor_position, want.cell_value, want.scrolled,
							want.ignored, rsp_word.cursor_row_out,
							rsp_word.cursor_col_out, rsp_word.cursor_position,
							rsp_word.cell_value, rsp_word.scrolled, rsp_word.ignored);
				end
			end
		end
	end

	// reset contents, field extremes and each corner of the command set
	task automatic test_directed_cases();
		send_cmd(make_cmd(FUNC_READ, '0, '0, '0, '0));
		send_cmd(make_cmd(FUNC_READ, '0, '0, ROW_LAST, COL_LAST));
		send_cmd(make_cmd(FUNC_PRINT, '0, '0, '0, '0));
		send_cmd(make_cmd(FUNC_PRINT, '1, '1, '1, '1));
		send_cmd(make_cmd(FUNC_PRINT, CHAR_RETURN, '1, '0, '0));
		send_cmd(make_cmd(FUNC_PRINT, CHAR_NEWLINE, '0, '0, '0));
		// delete across a row start, then within the row
		send_cmd(make_cmd(FUNC_DELETE, '0, '0, '0, '0));
		send_cmd(make_cmd(FUNC_DELETE, '1, '1, '1, '1));
		send_cmd(make_cmd(FUNC_MOVE, '0, '0, '0, '0));
		send_cmd(make_cmd(FUNC_DELETE, '0, '0, '0, '0));
		send_cmd(make_cmd(FUNC_MOVE, '0, '0, ROW_W'(ROW_COUNT), '0));
		send_cmd(make_cmd(FUNC_MOVE, '0, '0, '0, COL_W'(COL_COUNT)));
		send_cmd(make_cmd(FUNC_MOVE, '0, '0, '1, '1));
		send_cmd(make_cmd(FUNC_READ, '0, '0, '1, '1));
		send_cmd(make_cmd(FUNC_READ, '0, '0, ROW_LAST, COL_W'(COL_COUNT)));
		// print in the last cell: wrap and scroll
		send_cmd(make_cmd(FUNC_MOVE, '0, '0, ROW_LAST, COL_LAST));
		send_cmd(make_cmd(FUNC_PRINT, 8'h41, 8'h5A, '0, '0));
		send_cmd(make_cmd(FUNC_READ, '0, '0, ROW_LAST - ROW_W'(1), COL_LAST));
		send_cmd(make_cmd(FUNC_PRINT, CHAR_NEWLINE, '0, '0, '0));
		for (int f = FUNC_READ + 1; f <= FUNC_TOP; f++)
			send_cmd(make_cmd(FUNC_W'(f), '1, '1, '0, '0));
		send_cmd(make_cmd(FUNC_CLEAR, '0, '0, '0, '0));
		send_cmd(make_cmd(FUNC_READ, '0, '0, '0, COL_LAST));
	endtask

	// blank attribute at its extremes, seen through clear, delete and scroll
	task automatic test_blank_color();
		logic [7:0] settings [2];
		settings[0] = 8'h00;
		settings[1] = 8'hFF;
		foreach (settings[i]) begin
			write_blank(settings[i]);
			send_cmd(make_cmd(FUNC_CLEAR, '0, '0, '0, '0));
			send_cmd(make_cmd(FUNC_PRINT, 8'h78, 8'h3C, '0, '0));
			send_cmd(make_cmd(FUNC_DELETE, '0, '0, '0, '0));
			send_cmd(make_cmd(FUNC_READ, '0, '0, '0, '0));
			send_cmd(make_cmd(FUNC_MOVE, '0, '0, ROW_LAST, 7'd3));
			send_cmd(make_cmd(FUNC_PRINT, CHAR_NEWLINE, '0, '0, '0));
		end
	endtask

	task automatic test_random_traffic(input int count, input int snd_pct,
			input int rcv_pct);
		write_blank(8'($urandom_range(255)));
		send_idle_pct = snd_pct;
		rsp_idle_pct <= rcv_pct;
		repeat (count) send_cmd(random_cmd());
		wait_idle();
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_long_stall();
		send_idle_pct = 0;
		rsp_idle_pct <= 0;
		hold_left <= HOLD_CYCLES;
		repeat (40)
			send_cmd(make_cmd(FUNC_PRINT, CHAR_W'($urandom_range(126, 32)),
				CHAR_W'($urandom_range(255)), '0, '0));
		wait_idle();
	endtask

	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd_word  <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		blank_color = BLANK_RESET;
		blank_screen();
		cur_row = 0;
		cur_col = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_blank_color();
		test_random_traffic(620, 6, 76);
		test_random_traffic(620, 76, 6);
		test_long_stall();
		test_random_traffic(610, 0, 0);

		wait_idle();
		if (mismatch_count == 0 && pending_rsps.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
